FILE: hdl/ltsrt_pkg.sv
// Package for the link and time sync retry timer.
// Holds register indexes, reset values, status codes and the backoff helpers.
// No dependencies.
`timescale 1ns / 1ps

package ltsrt_pkg;

    // Configuration register geometry
    localparam int CFG_W     = 27;
    localparam int CFG_IDX_W = 3;
    localparam int MS_W      = 32;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CONNECT_TIMEOUT  = 3'd0,
        REG_SYNC_TIMEOUT     = 3'd1,
        REG_SYNC_BACKOFF_MIN = 3'd2,
        REG_SYNC_BACKOFF_MAX = 3'd3,
        REG_LINK_BACKOFF_MIN = 3'd4,
        REG_LINK_BACKOFF_MAX = 3'd5
    } cfg_idx_t;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_CONNECT_TIMEOUT = 27'd30000;
    localparam logic [CFG_W-1:0] RST_SYNC_TIMEOUT    = 27'd20000;
    localparam logic [CFG_W-1:0] RST_BACKOFF_MIN     = 27'd5000;
    localparam logic [CFG_W-1:0] RST_BACKOFF_MAX     = 27'd300000;

    // time_status codes
    localparam logic [1:0] TS_VALID   = 2'd0;
    localparam logic [1:0] TS_SYNCING = 2'd1;
    localparam logic [1:0] TS_NOT_SET = 2'd2;

    // Stream widths
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 104;

    // Backoff growth: saturate at hi once at least half of it, else double and clamp
    function automatic logic [CFG_W-1:0] grow_backoff(
        input logic [CFG_W-1:0] cur,
        input logic [CFG_W-1:0] lo,
        input logic [CFG_W-1:0] hi
    );
        logic [CFG_W:0]   dbl;
        logic [CFG_W-1:0] res;
        dbl = {cur, 1'b0};
        if (cur >= (hi >> 1))
            res = hi;
        else if (dbl < {1'b0, lo})
            res = lo;
        else if (dbl > {1'b0, hi})
            res = hi;
        else
            res = dbl[CFG_W-1:0];
        return res;
    endfunction

    // A nonzero retry time still lies ahead when now - at is negative
    function automatic logic still_waiting(
        input logic [MS_W-1:0] now,
        input logic [MS_W-1:0] at
    );
        logic [MS_W-1:0] diff;
        diff = now - at;
        return (at != '0) && diff[MS_W-1];
    endfunction

endpackage

FILE: hdl/link_and_time_sync_retry_timer.sv
// Link and time sync retry timer: two backoff retry machines on one tick stream.
// A request is held in the input register; compares and adds give a result that is
// registered in the result register. Throughput: one request per cycle unless output stalls.
// Reset (rst_n low, async): registers to their defaults, both machines idle,
// backoffs at the default minimum, pipeline empty. No clearing pass.
// Depends on ltsrt_pkg.
`timescale 1ns / 1ps

module link_and_time_sync_retry_timer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [ltsrt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ltsrt_pkg::CFG_W-1:0]           cfg_data,
    // request stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [31:0] now_ms, [32] link_up, [33] time_valid, [34] have_credentials,
    // [35] portal_forced, [39:36] zero
    input  logic [ltsrt_pkg::IN_DATA_W-1:0]       s_tdata,
    // [0] command
    input  logic                                  s_tuser,
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [0] start_time_sync, [1] start_connect, [2] drop_link, [3] enter_portal,
    // [5:4] time_status, [37:6] last_attempt_ms, [69:38] last_success_ms,
    // [101:70] retry_due_ms, [103:102] zero
    output logic [ltsrt_pkg::OUT_DATA_W-1:0]      m_tdata
);

    localparam int MS_W  = ltsrt_pkg::MS_W;
    localparam int CFG_W = ltsrt_pkg::CFG_W;

    // Configuration registers
    logic [CFG_W-1:0] connect_timeout_reg, sync_timeout_reg;
    logic [CFG_W-1:0] sync_bo_min_reg, sync_bo_max_reg;
    logic [CFG_W-1:0] link_bo_min_reg, link_bo_max_reg;

    // Pipeline registers
    logic                               in_valid_reg;
    logic [ltsrt_pkg::IN_DATA_W-1:0]    in_data_reg;
    logic                               in_cmd_reg;
    logic                               out_valid_reg;
    logic [ltsrt_pkg::OUT_DATA_W-1:0]   out_data_reg;

    // Machine state
    logic             sync_busy_reg, sync_busy_next;
    logic [MS_W-1:0]  sync_started_reg, sync_started_next;
    logic [MS_W-1:0]  sync_attempt_reg, sync_attempt_next;
    logic [MS_W-1:0]  sync_success_reg, sync_success_next;
    logic [MS_W-1:0]  sync_retry_reg, sync_retry_next;
    logic [CFG_W-1:0] sync_backoff_reg, sync_backoff_next;
    logic             time_was_valid_reg, time_was_valid_next;
    logic             link_busy_reg, link_busy_next;
    logic [MS_W-1:0]  link_started_reg, link_started_next;
    logic [MS_W-1:0]  link_retry_reg, link_retry_next;
    logic [CFG_W-1:0] link_backoff_reg, link_backoff_next;
    logic             portal_latched_reg, portal_latched_next;

    // Handshake
    logic advance;
    logic in_take;
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Field decode of the held request
    logic            f_cmd, f_link_up, f_tvalid, f_creds, f_forced;
    logic [MS_W-1:0] f_now;
    assign f_cmd     = in_cmd_reg;
    assign f_now     = in_data_reg[31:0];
    assign f_link_up = in_data_reg[32];
    assign f_tvalid  = in_data_reg[33];
    assign f_creds   = in_data_reg[34];
    assign f_forced  = in_data_reg[35];

    // Result flags
    logic            o_start_sync, o_start_conn, o_drop, o_portal;
    logic [1:0]      o_status;
    logic [MS_W-1:0] sync_elapsed, link_elapsed;
    logic [CFG_W-1:0] link_limit;

    assign sync_elapsed = f_now - sync_started_reg;
    assign link_elapsed = f_now - link_started_reg;
    assign link_limit   = (connect_timeout_reg == '0) ? CFG_W'(1) : connect_timeout_reg;

    // Next state for one request
    always_comb
    begin
        sync_busy_next      = sync_busy_reg;
        sync_started_next   = sync_started_reg;
        sync_attempt_next   = sync_attempt_reg;
        sync_success_next   = sync_success_reg;
        sync_retry_next     = sync_retry_reg;
        sync_backoff_next   = sync_backoff_reg;
        time_was_valid_next = time_was_valid_reg;
        link_busy_next      = link_busy_reg;
        link_started_next   = link_started_reg;
        link_retry_next     = link_retry_reg;
        link_backoff_next   = link_backoff_reg;
        portal_latched_next = portal_latched_reg;
        o_start_sync        = 1'b0;
        o_start_conn        = 1'b0;
        o_drop              = 1'b0;
        o_portal            = 1'b0;

        if (f_cmd)
        begin
            // portal request: latch setup mode and drop the link
            portal_latched_next = 1'b1;
            o_drop              = 1'b1;
            link_busy_next      = 1'b0;
            link_started_next   = '0;
            link_retry_next     = '0;
            link_backoff_next   = link_bo_min_reg;
        end
        else
        begin
            // time sync machine
            if (f_tvalid)
            begin
                time_was_valid_next = 1'b1;
                sync_busy_next      = 1'b0;
                sync_backoff_next   = sync_bo_min_reg;
                sync_retry_next     = '0;
                if (!time_was_valid_reg || sync_busy_reg || sync_success_reg == '0)
                    sync_success_next = f_now;
            end
            else
            begin
                time_was_valid_next = 1'b0;
                if (!f_link_up)
                    sync_busy_next = 1'b0;
                else if (sync_busy_reg)
                begin
                    if (sync_elapsed >= {{(MS_W-CFG_W){1'b0}}, sync_timeout_reg})
                    begin
                        sync_busy_next    = 1'b0;
                        sync_retry_next   = f_now + {{(MS_W-CFG_W){1'b0}}, sync_backoff_reg};
                        sync_backoff_next = ltsrt_pkg::grow_backoff(sync_backoff_reg,
                                                sync_bo_min_reg, sync_bo_max_reg);
                    end
                end
                else if (!ltsrt_pkg::still_waiting(f_now, sync_retry_reg))
                begin
                    sync_busy_next    = 1'b1;
                    sync_started_next = f_now;
                    sync_attempt_next = f_now;
                    o_start_sync      = 1'b1;
                end
            end

            // connect machine
            if (f_link_up)
            begin
                link_busy_next    = 1'b0;
                link_started_next = '0;
                link_retry_next   = '0;
                link_backoff_next = link_bo_min_reg;
            end
            else if (link_busy_reg)
            begin
                if (link_elapsed >= {{(MS_W-CFG_W){1'b0}}, link_limit})
                begin
                    o_drop            = 1'b1;
                    link_busy_next    = 1'b0;
                    link_started_next = '0;
                    link_retry_next   = f_now + {{(MS_W-CFG_W){1'b0}}, link_backoff_reg};
                    link_backoff_next = ltsrt_pkg::grow_backoff(link_backoff_reg,
                                            link_bo_min_reg, link_bo_max_reg);
                end
            end
            else if (portal_latched_reg || f_forced || !f_creds)
            begin
                o_portal            = 1'b1;
                portal_latched_next = 1'b0;
                link_busy_next      = 1'b0;
                link_started_next   = '0;
                link_retry_next     = '0;
                link_backoff_next   = link_bo_min_reg;
            end
            else if (!ltsrt_pkg::still_waiting(f_now, link_retry_reg))
            begin
                o_start_conn      = 1'b1;
                link_busy_next    = 1'b1;
                link_started_next = f_now;
                link_retry_next   = '0;
            end
        end

        // status after the update
        if (f_tvalid)
            o_status = ltsrt_pkg::TS_VALID;
        else if (sync_busy_next)
            o_status = ltsrt_pkg::TS_SYNCING;
        else
            o_status = ltsrt_pkg::TS_NOT_SET;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            connect_timeout_reg <= ltsrt_pkg::RST_CONNECT_TIMEOUT;
            sync_timeout_reg    <= ltsrt_pkg::RST_SYNC_TIMEOUT;
            sync_bo_min_reg     <= ltsrt_pkg::RST_BACKOFF_MIN;
            sync_bo_max_reg     <= ltsrt_pkg::RST_BACKOFF_MAX;
            link_bo_min_reg     <= ltsrt_pkg::RST_BACKOFF_MIN;
            link_bo_max_reg     <= ltsrt_pkg::RST_BACKOFF_MAX;
        end
        else if (cfg_wr_en)
        begin
            unique case (ltsrt_pkg::cfg_idx_t'(cfg_index))
                ltsrt_pkg::REG_CONNECT_TIMEOUT:  connect_timeout_reg <= cfg_data;
                ltsrt_pkg::REG_SYNC_TIMEOUT:     sync_timeout_reg    <= cfg_data;
                ltsrt_pkg::REG_SYNC_BACKOFF_MIN: sync_bo_min_reg     <= cfg_data;
                ltsrt_pkg::REG_SYNC_BACKOFF_MAX: sync_bo_max_reg     <= cfg_data;
                ltsrt_pkg::REG_LINK_BACKOFF_MIN: link_bo_min_reg     <= cfg_data;
                ltsrt_pkg::REG_LINK_BACKOFF_MAX: link_bo_max_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= s_tdata;
            in_cmd_reg  <= s_tuser;
        end
        if (advance)
            out_data_reg <= {2'b00, sync_retry_next, sync_success_next, sync_attempt_next,
                             o_status, o_portal, o_drop, o_start_conn, o_start_sync};
    end

    // Machine state, updated as each request moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_busy_reg      <= 1'b0;
            sync_started_reg   <= '0;
            sync_attempt_reg   <= '0;
            sync_success_reg   <= '0;
            sync_retry_reg     <= '0;
            sync_backoff_reg   <= ltsrt_pkg::RST_BACKOFF_MIN;
            time_was_valid_reg <= 1'b0;
            link_busy_reg      <= 1'b0;
            link_started_reg   <= '0;
            link_retry_reg     <= '0;
            link_backoff_reg   <= ltsrt_pkg::RST_BACKOFF_MIN;
            portal_latched_reg <= 1'b0;
        end
        else if (advance)
        begin
            sync_busy_reg      <= sync_busy_next;
            sync_started_reg   <= sync_started_next;
            sync_attempt_reg   <= sync_attempt_next;
            sync_success_reg   <= sync_success_next;
            sync_retry_reg     <= sync_retry_next;
            sync_backoff_reg   <= sync_backoff_next;
            time_was_valid_reg <= time_was_valid_next;
            link_busy_reg      <= link_busy_next;
            link_started_reg   <= link_started_next;
            link_retry_reg     <= link_retry_next;
            link_backoff_reg   <= link_backoff_next;
            portal_latched_reg <= portal_latched_next;
        end
    end

`ifndef NO_ASSERTIONS
    // a sync attempt never runs while time is already valid
    a_sync_busy_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        sync_busy_reg |-> !time_was_valid_reg)
        else $error("sync busy while time valid");

    // a running connect attempt has no retry scheduled
    a_link_busy_no_retry: assert property (@(posedge clk) disable iff (!rst_n)
        link_busy_reg |-> (link_retry_reg == '0))
        else $error("connect busy with retry pending");

    // connect start, drop and portal are exclusive in one result
    a_link_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($countones(out_data_reg[3:1]) <= 1))
        else $error("conflicting connect flags");

    // a request waiting behind a stalled result stays held
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |=> in_valid_reg)
        else $error("held request lost");
`endif

endmodule
